### design/saas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saas_pkg
// Shared constants, register indexes and log table helpers for the
// asymmetry anomaly scorer.
// ----------------------------------------------------------------------------
package saas_pkg;

  localparam int LOG_TABLE_BITS_DEF = 8;
  localparam int DIV_STEPS = 32;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 46;

  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_MEDIAN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_SIGMA     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ASYM_MEDIAN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ASYM_SIGMA       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ASYM_THRESHOLD   = 3'd5;

  localparam logic [31:0] VOLUME_MEDIAN_RST    = 32'd0;
  localparam logic [31:0] VOLUME_SIGMA_RST     = 32'd256;
  localparam logic [45:0] ASYM_MEDIAN_RST      = 46'd0;
  localparam logic [45:0] ASYM_SIGMA_RST       = 46'd65536;
  localparam logic [15:0] VOLUME_THRESHOLD_RST = 16'd2048;
  localparam logic [15:0] ASYM_THRESHOLD_RST   = 16'd2048;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // log2 of a Q1.31 mantissa in [1,2] as Q.30, bitwise squaring
  function automatic logic [30:0] log2_mant(input logic [63:0] m_in);
    logic [63:0] m;
    logic [30:0] r;
    m = m_in;
    r = '0;
    if (m >= 64'h1_0000_0000) begin
      return 31'h4000_0000;
    end
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [30:0] log_tab_entry(input int k, input int bits);
    logic [63:0] m;
    m = 64'h8000_0000 + (64'(k) << (31 - bits));
    return log2_mant(m);
  endfunction

endpackage

### design/saas_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saas_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module saas_div_pipe #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 24,
  parameter int QUO_W = saas_pkg::DIV_STEPS
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] low_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W-1:0] rem_prev;
    logic [DEN_W-1:0] den_prev;
    logic [QUO_W-1:0] low_prev;
    logic [QUO_W-1:0] quo_prev;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_prev = DEN_W'(num[NUM_W-1:QUO_W]);
      assign den_prev = den;
      assign low_prev = num[QUO_W-1:0];
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_r[k-1];
      assign den_prev = den_r[k-1];
      assign low_prev = low_r[k-1];
      assign quo_prev = quo_r[k-1];
    end

    assign trial = {rem_prev, low_prev[QUO_W-1-k]};
    assign ge    = trial >= {1'b0, den_prev};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
        den_r[k] <= den_prev;
        low_r[k] <= low_prev;
        quo_r[k] <= {quo_prev[QUO_W-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

### design/syn_asymmetry_anomaly_scorer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syn_asymmetry_anomaly_scorer_unit
// Per-second traffic sample scorer: asymmetry score, volume and asymmetry
// z-scores, and threshold alerts.
// ----------------------------------------------------------------------------
// One sample is taken every clock cycle while in_stall is low. The pipeline is
// built from two chains of 32-stage one-bit-per-stage dividers (ratios
// first, z-scores last) around a ten-stage log and multiply section. When
// out_stall holds a waiting result, the whole pipeline freezes and in_stall
// rises in the same cycle. Registers are written through the cfg port, which
// is always ready; write them only while no sample is in flight.
// ----------------------------------------------------------------------------
module syn_asymmetry_anomaly_scorer_unit #(
  parameter int LOG_TABLE_BITS = saas_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [23:0]                       in_flow_count,
  input  logic [23:0]                       in_forward_packets,
  input  logic [23:0]                       in_backward_packets,
  input  logic [23:0]                       in_oneway_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [45:0]                       out_asym_score,
  output logic signed [31:0]                out_vol_zscore,
  output logic signed [31:0]                out_asym_z,
  output logic                              out_vol_flag,
  output logic                              out_asym_flag,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [saas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [saas_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DIV_LAT = saas_pkg::DIV_STEPS;
  localparam int LAT     = 1 + DIV_LAT + 10 + 1 + DIV_LAT;
  localparam int TAB_N   = (1 << LOG_TABLE_BITS) + 1;
  localparam int REM_W   = 32 - LOG_TABLE_BITS;
  localparam int PROD_W  = 31 + REM_W;

  typedef struct packed {
    logic [23:0] flows;
    logic        zero;
    logic        ovf_a;
    logic        ovf_b;
  } ratio_side_t;

  typedef struct packed {
    logic [23:0] flows;
    logic [32:0] b;
  } log_side_t;

  typedef struct packed {
    logic [45:0] score;
    logic        vneg;
    logic        vovf;
    logic        aneg;
    logic        aovf;
  } z_side_t;

  // configuration
  logic [31:0] vol_med_r;
  logic [31:0] vol_sig_r;
  logic [45:0] asym_med_r;
  logic [45:0] asym_sig_r;
  logic [15:0] vol_th_r;
  logic [15:0] asym_th_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_med_r  <= saas_pkg::VOLUME_MEDIAN_RST;
      vol_sig_r  <= saas_pkg::VOLUME_SIGMA_RST;
      asym_med_r <= saas_pkg::ASYM_MEDIAN_RST;
      asym_sig_r <= saas_pkg::ASYM_SIGMA_RST;
      vol_th_r   <= saas_pkg::VOLUME_THRESHOLD_RST;
      asym_th_r  <= saas_pkg::ASYM_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        saas_pkg::REG_VOLUME_MEDIAN:    vol_med_r  <= cfg_data[31:0];
        saas_pkg::REG_VOLUME_SIGMA:     vol_sig_r  <= cfg_data[31:0];
        saas_pkg::REG_ASYM_MEDIAN:      asym_med_r <= cfg_data;
        saas_pkg::REG_ASYM_SIGMA:       asym_sig_r <= cfg_data;
        saas_pkg::REG_VOLUME_THRESHOLD: vol_th_r   <= cfg_data[15:0];
        saas_pkg::REG_ASYM_THRESHOLD:   asym_th_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  logic out_valid_r;
  logic vld_r [LAT];

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // input stage
  logic [23:0] s0_flows_r;
  logic [24:0] s0_fwd1_r;
  logic [24:0] s0_bwd1_r;
  logic [23:0] s0_ow_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_flows_r <= in_flow_count;
      s0_fwd1_r  <= {1'b0, in_forward_packets} + 25'd1;
      s0_bwd1_r  <= {1'b0, in_backward_packets} + 25'd1;
      s0_ow_r    <= in_oneway_count;
    end
  end

  // ratio dividers
  logic [31:0] qa;
  logic [31:0] qb;
  ratio_side_t rs_in;
  ratio_side_t rs_r [DIV_LAT];

  saas_div_pipe #(.NUM_W(40), .DEN_W(24), .QUO_W(DIV_LAT)) u_div_owr (
    .clk (clk),
    .en  (en),
    .num ({s0_ow_r, 16'b0}),
    .den (s0_flows_r),
    .quo (qa)
  );

  saas_div_pipe #(.NUM_W(41), .DEN_W(25), .QUO_W(DIV_LAT)) u_div_fbr (
    .clk (clk),
    .en  (en),
    .num ({s0_fwd1_r, 16'b0}),
    .den (s0_bwd1_r),
    .quo (qb)
  );

  always_comb begin
    rs_in.flows = s0_flows_r;
    rs_in.zero  = (s0_flows_r == 24'd0);
    rs_in.ovf_a = {16'b0, s0_ow_r} >= {s0_flows_r, 16'b0};
    rs_in.ovf_b = {16'b0, s0_fwd1_r} >= {s0_bwd1_r, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_r[0] <= rs_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        rs_r[k] <= rs_r[k-1];
      end
    end
  end

  // p1: ratio select
  logic [31:0] owr;
  logic [31:0] fbr;
  logic [32:0] p1_y_r;
  log_side_t   ls_nxt;
  log_side_t   ls_r [8];

  always_comb begin
    if (rs_r[DIV_LAT-1].zero) begin
      owr = 32'd0;
    end else if (rs_r[DIV_LAT-1].ovf_a) begin
      owr = 32'hFFFF_FFFF;
    end else begin
      owr = qa;
    end
    fbr = rs_r[DIV_LAT-1].ovf_b ? 32'hFFFF_FFFF : qb;
    ls_nxt.flows = rs_r[DIV_LAT-1].flows;
    ls_nxt.b     = {1'b0, owr} + 33'h1_0000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_y_r   <= {1'b0, fbr} + 33'h1_0000;
      ls_r[0] <= ls_nxt;
      for (int k = 1; k < 8; k++) begin
        ls_r[k] <= ls_r[k-1];
      end
    end
  end

  // p2: leading one
  logic [4:0]  p2_e_nxt;
  logic [4:0]  p2_e_r;
  logic [32:0] p2_y_r;

  always_comb begin
    p2_e_nxt = 5'd0;
    for (int i = 17; i <= 32; i++) begin
      if (p1_y_r[i]) begin
        p2_e_nxt = 5'(i - 16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_e_r <= p2_e_nxt;
      p2_y_r <= p1_y_r;
    end
  end

  // p3: normalize
  logic [48:0]               p3_ys;
  logic [LOG_TABLE_BITS-1:0] p3_idx_r;
  logic [REM_W-1:0]          p3_rem_r;
  logic [4:0]                p3_e_r;

  assign p3_ys = {16'b0, p2_y_r} << (5'd16 - p2_e_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p3_idx_r <= p3_ys[31 -: LOG_TABLE_BITS];
      p3_rem_r <= p3_ys[REM_W-1:0];
      p3_e_r   <= p2_e_r;
    end
  end

  // p4: table lookup
  logic [30:0] log_tab [TAB_N];

  for (genvar k = 0; k < TAB_N; k++) begin : g_tab
    localparam logic [30:0] ENTRY = saas_pkg::log_tab_entry(k, LOG_TABLE_BITS);
    assign log_tab[k] = ENTRY;
  end

  logic [30:0]      p4_lo_r;
  logic [30:0]      p4_hi_r;
  logic [REM_W-1:0] p4_rem_r;
  logic [4:0]       p4_e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_lo_r  <= log_tab[p3_idx_r];
      p4_hi_r  <= log_tab[{1'b0, p3_idx_r} + (LOG_TABLE_BITS+1)'(1)];
      p4_rem_r <= p3_rem_r;
      p4_e_r   <= p3_e_r;
    end
  end

  // p5: interpolation product
  logic [30:0]       p5_diff;
  logic [PROD_W-1:0] p5_prod_r;
  logic [30:0]       p5_lo_r;
  logic [4:0]        p5_e_r;

  assign p5_diff = (p4_hi_r > p4_lo_r) ? (p4_hi_r - p4_lo_r) : 31'd0;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_prod_r <= PROD_W'(p5_diff) * PROD_W'(p4_rem_r);
      p5_lo_r   <= p4_lo_r;
      p5_e_r    <= p4_e_r;
    end
  end

  // p6: log2 sum
  logic [31:0] p6_t;
  logic [34:0] p6_lg;
  logic [24:0] p6_lgs_r;

  assign p6_t  = {1'b0, p5_lo_r} + {1'b0, p5_prod_r[PROD_W-1:REM_W]};
  assign p6_lg = {p5_e_r, 30'b0} + 35'(p6_t);

  always_ff @(posedge clk) begin
    if (en) begin
      p6_lgs_r <= p6_lg[34:10];
    end
  end

  // p7: scale by ln2
  logic [54:0] p7_m_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p7_m_r <= 55'(p6_lgs_r) * 55'(saas_pkg::LN2_Q30);
    end
  end

  // p8: round and scale by flows
  logic [55:0] p8_rnd;
  logic [45:0] p8_a_r;

  assign p8_rnd = {1'b0, p7_m_r} + 56'h2_0000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      p8_a_r <= 46'(ls_r[6].flows) * 46'(p8_rnd[55:34]);
    end
  end

  // p9: partial products
  logic [56:0] p9_plo_r;
  logic [54:0] p9_phi_r;
  logic [23:0] p9_flows_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p9_plo_r   <= 57'(p8_a_r[23:0]) * 57'(ls_r[7].b);
      p9_phi_r   <= 55'(p8_a_r[45:24]) * 55'(ls_r[7].b);
      p9_flows_r <= ls_r[7].flows;
    end
  end

  // p10: score
  logic [78:0] p10_full;
  logic [45:0] p10_score_r;
  logic [23:0] p10_flows_r;

  assign p10_full = {p9_phi_r, 24'b0} + 79'(p9_plo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p10_score_r <= (|p10_full[78:62]) ? '1 : p10_full[61:16];
      p10_flows_r <= p9_flows_r;
    end
  end

  // z1: deviation magnitudes
  logic [31:0] z1_vval;
  logic        z1_vneg_nxt;
  logic        z1_aneg_nxt;
  logic [31:0] z1_vmag_r;
  logic [31:0] z1_vsig_r;
  logic        z1_vneg_r;
  logic [45:0] z1_amag_r;
  logic [45:0] z1_asig_r;
  logic        z1_aneg_r;
  logic [45:0] z1_score_r;

  assign z1_vval     = {p10_flows_r, 8'b0};
  assign z1_vneg_nxt = z1_vval < vol_med_r;
  assign z1_aneg_nxt = p10_score_r < asym_med_r;

  always_ff @(posedge clk) begin
    if (en) begin
      z1_vmag_r  <= z1_vneg_nxt ? (vol_med_r - z1_vval) : (z1_vval - vol_med_r);
      z1_vsig_r  <= (vol_sig_r == 32'd0) ? 32'd1 : vol_sig_r;
      z1_vneg_r  <= z1_vneg_nxt;
      z1_amag_r  <= z1_aneg_nxt ? (asym_med_r - p10_score_r) : (p10_score_r - asym_med_r);
      z1_asig_r  <= (asym_sig_r == 46'd0) ? 46'd1 : asym_sig_r;
      z1_aneg_r  <= z1_aneg_nxt;
      z1_score_r <= p10_score_r;
    end
  end

  // z-score dividers
  logic [31:0] qv;
  logic [31:0] qz;
  z_side_t     zs_in;
  z_side_t     zs_r [DIV_LAT];

  saas_div_pipe #(.NUM_W(40), .DEN_W(32), .QUO_W(DIV_LAT)) u_div_vz (
    .clk (clk),
    .en  (en),
    .num ({z1_vmag_r, 8'b0}),
    .den (z1_vsig_r),
    .quo (qv)
  );

  saas_div_pipe #(.NUM_W(54), .DEN_W(46), .QUO_W(DIV_LAT)) u_div_az (
    .clk (clk),
    .en  (en),
    .num ({z1_amag_r, 8'b0}),
    .den (z1_asig_r),
    .quo (qz)
  );

  always_comb begin
    zs_in.score = z1_score_r;
    zs_in.vneg  = z1_vneg_r;
    zs_in.vovf  = {24'b0, z1_vmag_r} >= {z1_vsig_r, 24'b0};
    zs_in.aneg  = z1_aneg_r;
    zs_in.aovf  = {24'b0, z1_amag_r} >= {z1_asig_r, 24'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zs_r[0] <= zs_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        zs_r[k] <= zs_r[k-1];
      end
    end
  end

  // output stage
  function automatic logic [31:0] z_sat(input logic neg, input logic ovf,
                                        input logic [31:0] q);
    logic [31:0] mag;
    if (neg) begin
      mag = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : q;
      return ~mag + 32'd1;
    end
    return (ovf || q[31]) ? 32'h7FFF_FFFF : q;
  endfunction

  logic [31:0] vz_nxt;
  logic [31:0] az_nxt;
  logic [45:0] score_r;
  logic [31:0] vz_r;
  logic [31:0] az_r;
  logic        valert_r;
  logic        aalert_r;

  assign vz_nxt = z_sat(zs_r[DIV_LAT-1].vneg, zs_r[DIV_LAT-1].vovf, qv);
  assign az_nxt = z_sat(zs_r[DIV_LAT-1].aneg, zs_r[DIV_LAT-1].aovf, qz);

  always_ff @(posedge clk) begin
    if (en) begin
      score_r  <= zs_r[DIV_LAT-1].score;
      vz_r     <= vz_nxt;
      az_r     <= az_nxt;
      valert_r <= $signed(vz_nxt) > $signed({{16{vol_th_r[15]}}, vol_th_r});
      aalert_r <= $signed(az_nxt) > $signed({{16{asym_th_r[15]}}, asym_th_r});
    end
  end

  assign out_valid      = out_valid_r;
  assign out_asym_score = score_r;
  assign out_vol_zscore = $signed(vz_r);
  assign out_asym_z     = $signed(az_r);
  assign out_vol_flag   = valert_r;
  assign out_asym_flag  = aalert_r;

endmodule

### design/saas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saas_checker
// Port-level checks for the asymmetry anomaly scorer, bound to the top level.
// ----------------------------------------------------------------------------
module saas_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [45:0]        out_asym_score,
  input logic signed [31:0] out_vol_zscore,
  input logic signed [31:0] out_asym_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_asym_score) &&
      $stable(out_vol_zscore) && $stable(out_asym_z))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind syn_asymmetry_anomaly_scorer_unit saas_checker u_saas_checker (.*);
